/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* design/wtdw_pkg.sv */
// ----------------------------------------------------------------------------
// Downwash wake package
// Widths, constants, CORDIC tables and the side data carried by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package wtdw_pkg;

    localparam int ADDR_W = 5;
    localparam int VW     = 45;   // vectoring x/z
    localparam int AW     = 33;   // angles
    localparam int RW     = 34;   // rotation x/y

    localparam logic [2:0] REG_REF_BODY_ALPHA = 3'd0;
    localparam logic [2:0] REG_REF_DOWNWASH   = 3'd1;
    localparam logic [2:0] REG_ALPHA_GRADIENT = 3'd2;
    localparam logic [2:0] REG_REF_FLAP       = 3'd3;
    localparam logic [2:0] REG_FLAP_GRADIENT  = 3'd4;
    localparam logic [2:0] REG_PRESSURE_RATIO = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [AW-1:0] Q28_PI      = 33'sd843314857;
    localparam logic signed [AW-1:0] Q28_TWO_PI  = 33'sd1686629713;
    localparam logic signed [AW-1:0] Q28_HALF_PI = 33'sd421657428;
    localparam logic [31:0]          Q28_QUARTER_PI = 32'd210828714;

    localparam logic signed [32:0] ROT_LIM   = 33'sd4294967295;
    localparam logic [31:0]        SCALE_ONE = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [32:0] fd;
        logic signed [31:0] dw;
        logic               zero;
        logic               xz0;
        logic               sat;
        logic               flip;
    } side_t;

    // shift-and-subtract quotient, evaluated for table constants only
    function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [31:0] atan_entry(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        sum = 64'd0;
        if (i == 0)
        begin
            return Q28_QUARTER_PI;
        end
        for (k = 0; i * (2 * k + 1) <= 60; k++)
        begin
            term = const_div(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k[0] == 1'b1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return 32'((sum + (64'd1 << 31)) >> 32);
    endfunction

    function automatic logic [31:0] cordic_gain(input int nstg);
        logic [63:0] k2;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        k2 = 64'd1 << 62;
        for (i = 0; i < nstg; i++)
        begin
            k2 = k2 - const_div(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        v = k2;
        r = 64'd0;
        for (i = 0; i < 32; i++)
        begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return 32'((r + 64'd1) >> 1);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -68'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic logic ovf32(input logic signed [67:0] v);
        return (v > 68'sd2147483647) || (v < -68'sd2147483648);
    endfunction

endpackage
`default_nettype wire

/* design/wtdw_in_if.sv */
// ----------------------------------------------------------------------------
// Velocity input channel
// Valid/ready beat carrying body velocity and flap angle.
// ----------------------------------------------------------------------------
`default_nettype none
interface wtdw_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] flap_angle;

    modport source (output valid, output vel_x, output vel_y, output vel_z,
                    output flap_angle, input ready);
    modport sink (input valid, input vel_x, input vel_y, input vel_z,
                  input flap_angle, output ready);
endinterface
`default_nettype wire

/* design/wtdw_out_if.sv */
// ----------------------------------------------------------------------------
// Wake output channel
// Valid/ready beat carrying downwash, wake velocity, increment and status.
// ----------------------------------------------------------------------------
`default_nettype none
interface wtdw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] downwash_angle;
    logic signed [31:0] wake_x;
    logic signed [31:0] wake_y;
    logic signed [31:0] wake_z;
    logic signed [31:0] incr_x;
    logic signed [31:0] incr_y;
    logic signed [31:0] incr_z;
    logic [1:0]         status;

    modport source (output valid, output downwash_angle, output wake_x, output wake_y,
                    output wake_z, output incr_x, output incr_y, output incr_z,
                    output status, input ready);
    modport sink (input valid, input downwash_angle, input wake_x, input wake_y,
                  input wake_z, input incr_x, input incr_y, input incr_z,
                  input status, output ready);
endinterface
`default_nettype wire

/* design/wtdw_cordic_vec.sv */
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// One register stage per iteration; drives z to zero and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none
module wtdw_cordic_vec #(
    parameter int STAGES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [wtdw_pkg::VW-1:0] in_x,
    input  logic signed [wtdw_pkg::VW-1:0] in_z,
    input  logic signed [wtdw_pkg::AW-1:0] in_ang,
    input  wtdw_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic signed [wtdw_pkg::AW-1:0] out_ang,
    output wtdw_pkg::side_t               out_side
);
    import wtdw_pkg::*;

    logic               v_reg    [STAGES];
    logic signed [VW-1:0] x_reg  [STAGES];
    logic signed [VW-1:0] z_reg  [STAGES];
    logic signed [AW-1:0] ang_reg [STAGES];
    side_t              side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] TAB = AW'(atan_entry(i));
        logic                 v_src;
        logic signed [VW-1:0] x_src;
        logic signed [VW-1:0] z_src;
        logic signed [AW-1:0] ang_src;
        side_t                side_src;
        logic signed [VW-1:0] x_next;
        logic signed [VW-1:0] z_next;
        logic signed [AW-1:0] ang_next;

        if (i == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign x_src    = in_x;
            assign z_src    = in_z;
            assign ang_src  = in_ang;
            assign side_src = in_side;
        end
        else
        begin : g_rest
            assign v_src    = v_reg[i-1];
            assign x_src    = x_reg[i-1];
            assign z_src    = z_reg[i-1];
            assign ang_src  = ang_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        always_comb
        begin
            if (!z_src[VW-1])
            begin
                x_next   = x_src + (z_src >>> i);
                z_next   = z_src - (x_src >>> i);
                ang_next = ang_src + TAB;
            end
            else
            begin
                x_next   = x_src - (z_src >>> i);
                z_next   = z_src + (x_src >>> i);
                ang_next = ang_src - TAB;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= x_next;
                z_reg[i]    <= z_next;
                ang_reg[i]  <= ang_next;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_ang   = ang_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
`default_nettype wire

/* design/wtdw_cordic_rot.sv */
// ----------------------------------------------------------------------------
// Rotation CORDIC pipeline
// One register stage per iteration; turns the gain vector to give cos and sin.
// ----------------------------------------------------------------------------
`default_nettype none
module wtdw_cordic_rot #(
    parameter int STAGES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [wtdw_pkg::AW-1:0] in_ang,
    input  wtdw_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic signed [wtdw_pkg::RW-1:0] out_cos,
    output logic signed [wtdw_pkg::RW-1:0] out_sin,
    output wtdw_pkg::side_t               out_side
);
    import wtdw_pkg::*;

    localparam logic signed [RW-1:0] GAIN = RW'(cordic_gain(STAGES));

    logic                 v_reg    [STAGES];
    logic signed [RW-1:0] x_reg    [STAGES];
    logic signed [RW-1:0] y_reg    [STAGES];
    logic signed [AW-1:0] a_reg    [STAGES];
    side_t                side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] TAB = AW'(atan_entry(i));
        logic                 v_src;
        logic signed [RW-1:0] x_src;
        logic signed [RW-1:0] y_src;
        logic signed [AW-1:0] a_src;
        side_t                side_src;
        logic signed [RW-1:0] x_next;
        logic signed [RW-1:0] y_next;
        logic signed [AW-1:0] a_next;

        if (i == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign x_src    = GAIN;
            assign y_src    = '0;
            assign a_src    = in_ang;
            assign side_src = in_side;
        end
        else
        begin : g_rest
            assign v_src    = v_reg[i-1];
            assign x_src    = x_reg[i-1];
            assign y_src    = y_reg[i-1];
            assign a_src    = a_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        always_comb
        begin
            if (!a_src[AW-1])
            begin
                x_next = x_src - (y_src >>> i);
                y_next = y_src + (x_src >>> i);
                a_next = a_src - TAB;
            end
            else
            begin
                x_next = x_src + (y_src >>> i);
                y_next = y_src - (x_src >>> i);
                a_next = a_src + TAB;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                a_reg[i]    <= a_next;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_cos   = x_reg[STAGES-1];
    assign out_sin   = y_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
`default_nettype wire

/* design/wing_tail_downwash_wake.sv */
// ----------------------------------------------------------------------------
// Wing downwash at the tail
// Angle of attack, linear downwash, rotated and scaled wake velocity.
// ----------------------------------------------------------------------------
// Usage:
//   vel  : input beats of vel_x, vel_y, vel_z (Q16.16) and flap_angle (Q4.28).
//   wake : output beats of downwash_angle, wake_x/y/z, incr_x/y/z and status.
//   APB  : six 32-bit registers at byte addresses 0x00..0x14; reads return them.
// Throughput: one beat per cycle while neither the wake sink nor the square root
//   stalls it. Stages: S0..S2, vector CORDIC, A1..A4, rotate CORDIC, B1..B5.
// A write to pressure_ratio starts the square-root unit; vel.ready is
//   low while it runs.
// Reset clears all valid bits, loads the register reset values and a scale
//   of 1.0; no clearing pass is needed.
// When the wake sink stalls, the whole pipeline holds and vel.ready drops in
//   the same cycle; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module wing_tail_downwash_wake #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wtdw_in_if.sink                       vel,
    wtdw_out_if.source                    wake,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wtdw_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import wtdw_pkg::*;

    // configuration
    logic signed [31:0] rba_reg;
    logic signed [31:0] rdw_reg;
    logic signed [31:0] ag_reg;
    logic signed [31:0] rf_reg;
    logic signed [31:0] fg_reg;
    logic [31:0]        pr_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rba_reg <= '0;
            rdw_reg <= '0;
            ag_reg  <= '0;
            rf_reg  <= '0;
            fg_reg  <= '0;
            pr_reg  <= SCALE_ONE;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_REF_BODY_ALPHA: rba_reg <= pwdata;
                REG_REF_DOWNWASH:   rdw_reg <= pwdata;
                REG_ALPHA_GRADIENT: ag_reg  <= pwdata;
                REG_REF_FLAP:       rf_reg  <= pwdata;
                REG_FLAP_GRADIENT:  fg_reg  <= pwdata;
                REG_PRESSURE_RATIO: pr_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_REF_BODY_ALPHA: prdata = rba_reg;
            REG_REF_DOWNWASH:   prdata = rdw_reg;
            REG_ALPHA_GRADIENT: prdata = ag_reg;
            REG_REF_FLAP:       prdata = rf_reg;
            REG_FLAP_GRADIENT:  prdata = fg_reg;
            REG_PRESSURE_RATIO: prdata = pr_reg;
            default:            prdata = '0;
        endcase
    end

    // square root of the pressure ratio, one result bit a cycle
    logic        sq_busy_reg;
    logic [4:0]  sq_cnt_reg;
    logic [62:0] sq_v_reg;
    logic [62:0] sq_r_reg;
    logic [31:0] scale_reg;
    logic [62:0] sq_b;
    logic [62:0] sq_t;
    logic [62:0] sq_v_next;
    logic [62:0] sq_r_next;

    always_comb
    begin
        sq_b = 63'd1 << {sq_cnt_reg, 1'b0};
        sq_t = sq_r_reg + sq_b;
        if (sq_v_reg >= sq_t)
        begin
            sq_v_next = sq_v_reg - sq_t;
            sq_r_next = (sq_r_reg >> 1) + sq_b;
        end
        else
        begin
            sq_v_next = sq_v_reg;
            sq_r_next = sq_r_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
            sq_v_reg    <= '0;
            sq_r_reg    <= '0;
            scale_reg   <= SCALE_ONE;
        end
        else if (cfg_wr && cfg_idx == REG_PRESSURE_RATIO)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= 5'd31;
            sq_v_reg    <= {1'b0, pwdata, 30'd0};
            sq_r_reg    <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_v_reg   <= sq_v_next;
            sq_r_reg   <= sq_r_next;
            sq_cnt_reg <= sq_cnt_reg - 5'd1;
            if (sq_cnt_reg == 5'd0)
            begin
                sq_busy_reg <= 1'b0;
                scale_reg   <= 32'(sq_r_next + ((sq_v_next > sq_r_next) ? 63'd1 : 63'd0));
            end
        end
    end

    // pipeline control
    logic wake_valid_reg;
    logic adv;

    assign adv       = !wake_valid_reg || wake.ready;
    assign vel.ready = adv && !sq_busy_reg;

    // S0: capture, half-turn for negative x
    logic                 s0_v_reg;
    logic signed [32:0]   s0_x_reg;
    logic signed [32:0]   s0_z_reg;
    logic signed [AW-1:0] s0_ang_reg;
    side_t                s0_side_reg;
    logic signed [32:0]   s0_x_next;
    logic signed [32:0]   s0_z_next;
    logic signed [AW-1:0] s0_ang_next;
    side_t                s0_side_next;

    always_comb
    begin
        s0_side_next.vx   = vel.vel_x;
        s0_side_next.vy   = vel.vel_y;
        s0_side_next.vz   = vel.vel_z;
        s0_side_next.fd   = 33'(vel.flap_angle) - 33'(rf_reg);
        s0_side_next.dw   = '0;
        s0_side_next.zero = (vel.vel_x == 0) && (vel.vel_y == 0) && (vel.vel_z == 0);
        s0_side_next.xz0  = (vel.vel_x == 0) && (vel.vel_z == 0);
        s0_side_next.sat  = 1'b0;
        s0_side_next.flip = 1'b0;
        if (vel.vel_x[31])
        begin
            s0_x_next   = -33'(vel.vel_x);
            s0_z_next   = -33'(vel.vel_z);
            s0_ang_next = vel.vel_z[31] ? -Q28_PI : Q28_PI;
        end
        else
        begin
            s0_x_next   = 33'(vel.vel_x);
            s0_z_next   = 33'(vel.vel_z);
            s0_ang_next = '0;
        end
    end

    // S1: larger magnitude
    logic                 s1_v_reg;
    logic signed [32:0]   s1_x_reg;
    logic signed [32:0]   s1_z_reg;
    logic signed [AW-1:0] s1_ang_reg;
    side_t                s1_side_reg;
    logic [31:0]          s1_m_reg;
    logic [32:0]          s1_za;
    logic [31:0]          s1_m_next;

    always_comb
    begin
        s1_za     = s0_z_reg[32] ? 33'(-s0_z_reg) : 33'(s0_z_reg);
        s1_m_next = (33'(s0_x_reg) > s1_za) ? 32'(s0_x_reg) : 32'(s1_za);
    end

    // S2: normalize to a leading one at bit 40
    logic                 s2_v_reg;
    logic signed [VW-1:0] s2_x_reg;
    logic signed [VW-1:0] s2_z_reg;
    logic signed [AW-1:0] s2_ang_reg;
    side_t                s2_side_reg;
    logic [4:0]           s2_pos;
    logic [5:0]           s2_sh;

    always_comb
    begin
        s2_pos = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (s1_m_reg[k])
            begin
                s2_pos = 5'(k);
            end
        end
        s2_sh = 6'd40 - {1'b0, s2_pos};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_v_reg <= vel.valid && !sq_busy_reg;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg    <= s0_x_next;
            s0_z_reg    <= s0_z_next;
            s0_ang_reg  <= s0_ang_next;
            s0_side_reg <= s0_side_next;
            s1_x_reg    <= s0_x_reg;
            s1_z_reg    <= s0_z_reg;
            s1_ang_reg  <= s0_ang_reg;
            s1_side_reg <= s0_side_reg;
            s1_m_reg    <= s1_m_next;
            s2_x_reg    <= VW'(s1_x_reg) <<< s2_sh;
            s2_z_reg    <= VW'(s1_z_reg) <<< s2_sh;
            s2_ang_reg  <= s1_ang_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    logic                 vec_v;
    logic signed [AW-1:0] vec_ang;
    side_t                vec_side;

    wtdw_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s2_v_reg),
        .in_x     (s2_x_reg),
        .in_z     (s2_z_reg),
        .in_ang   (s2_ang_reg),
        .in_side  (s2_side_reg),
        .out_valid(vec_v),
        .out_ang  (vec_ang),
        .out_side (vec_side)
    );

    // A1..A4: downwash and angle reduction
    logic                 a1_v_reg;
    logic signed [33:0]   a1_ad_reg;
    side_t                a1_side_reg;
    logic signed [AW-1:0] a1_alpha;

    logic                 a2_v_reg;
    logic signed [65:0]   a2_pa_reg;
    logic signed [65:0]   a2_pf_reg;
    side_t                a2_side_reg;

    logic                 a3_v_reg;
    side_t                a3_side_reg;
    logic signed [65:0]   a3_pa_r;
    logic signed [65:0]   a3_pf_r;
    logic signed [67:0]   a3_sum;
    side_t                a3_side_next;

    logic                 a4_v_reg;
    logic signed [AW-1:0] a4_a_reg;
    side_t                a4_side_reg;
    logic signed [AW-1:0] a4_w;
    logic signed [AW-1:0] a4_a_next;
    side_t                a4_side_next;

    assign a1_alpha = vec_side.xz0 ? '0 : vec_ang;

    always_comb
    begin
        a3_pa_r = (a2_pa_reg + 66'sd134217728) >>> 28;
        a3_pf_r = (a2_pf_reg + 66'sd134217728) >>> 28;
        a3_sum  = 68'(rdw_reg) + 68'(a3_pa_r) + 68'(a3_pf_r);
        a3_side_next     = a2_side_reg;
        a3_side_next.dw  = sat32(a3_sum);
        a3_side_next.sat = ovf32(a3_sum);
    end

    always_comb
    begin
        a4_w = AW'(a3_side_reg.dw);
        if (a4_w > Q28_PI)
        begin
            a4_w = a4_w - Q28_TWO_PI;
        end
        else if (a4_w < -Q28_PI)
        begin
            a4_w = a4_w + Q28_TWO_PI;
        end
        a4_side_next = a3_side_reg;
        if (a4_w > Q28_HALF_PI)
        begin
            a4_a_next         = a4_w - Q28_PI;
            a4_side_next.flip = 1'b1;
        end
        else if (a4_w < -Q28_HALF_PI)
        begin
            a4_a_next         = a4_w + Q28_PI;
            a4_side_next.flip = 1'b1;
        end
        else
        begin
            a4_a_next         = a4_w;
            a4_side_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_v_reg <= 1'b0;
            a2_v_reg <= 1'b0;
            a3_v_reg <= 1'b0;
            a4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a1_v_reg <= vec_v;
            a2_v_reg <= a1_v_reg;
            a3_v_reg <= a2_v_reg;
            a4_v_reg <= a3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_ad_reg   <= 34'(a1_alpha) - 34'(rba_reg);
            a1_side_reg <= vec_side;
            a2_pa_reg   <= 66'(ag_reg) * 66'(a1_ad_reg);
            a2_pf_reg   <= 66'(fg_reg) * 66'(a1_side_reg.fd);
            a2_side_reg <= a1_side_reg;
            a3_side_reg <= a3_side_next;
            a4_a_reg    <= a4_a_next;
            a4_side_reg <= a4_side_next;
        end
    end

    logic                 rot_v;
    logic signed [RW-1:0] rot_c;
    logic signed [RW-1:0] rot_s;
    side_t                rot_side;

    wtdw_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (a4_v_reg),
        .in_ang   (a4_a_reg),
        .in_side  (a4_side_reg),
        .out_valid(rot_v),
        .out_cos  (rot_c),
        .out_sin  (rot_s),
        .out_side (rot_side)
    );

    // B1..B4: rotate and scale
    logic                 b1_v_reg;
    logic signed [RW-1:0] b1_c_reg;
    logic signed [RW-1:0] b1_s_reg;
    side_t                b1_side_reg;

    logic                 b2_v_reg;
    logic signed [65:0]   b2_cvx_reg;
    logic signed [65:0]   b2_svz_reg;
    logic signed [65:0]   b2_cvz_reg;
    logic signed [65:0]   b2_svx_reg;
    side_t                b2_side_reg;

    logic                 b3_v_reg;
    logic signed [32:0]   b3_rx_reg;
    logic signed [32:0]   b3_rz_reg;
    side_t                b3_side_reg;
    logic signed [66:0]   b3_sx;
    logic signed [66:0]   b3_sz;
    logic signed [32:0]   b3_rx_next;
    logic signed [32:0]   b3_rz_next;

    logic                 b4_v_reg;
    logic signed [65:0]   b4_px_reg;
    logic signed [65:0]   b4_py_reg;
    logic signed [65:0]   b4_pz_reg;
    side_t                b4_side_reg;
    logic signed [32:0]   b4_scale;

    always_comb
    begin
        b3_sx = ((67'(b2_cvx_reg) + 67'(b2_svz_reg)) + 67'sd536870912) >>> 30;
        b3_sz = ((67'(b2_cvz_reg) - 67'(b2_svx_reg)) + 67'sd536870912) >>> 30;
        if (b3_sx > 67'(ROT_LIM))
        begin
            b3_rx_next = ROT_LIM;
        end
        else if (b3_sx < -67'(ROT_LIM))
        begin
            b3_rx_next = -ROT_LIM;
        end
        else
        begin
            b3_rx_next = 33'(b3_sx);
        end
        if (b3_sz > 67'(ROT_LIM))
        begin
            b3_rz_next = ROT_LIM;
        end
        else if (b3_sz < -67'(ROT_LIM))
        begin
            b3_rz_next = -ROT_LIM;
        end
        else
        begin
            b3_rz_next = 33'(b3_sz);
        end
    end

    assign b4_scale = $signed({1'b0, scale_reg});

    // B5: round, saturate, increment
    logic signed [31:0] out_dw_reg;
    logic signed [31:0] out_wx_reg;
    logic signed [31:0] out_wy_reg;
    logic signed [31:0] out_wz_reg;
    logic signed [31:0] out_ix_reg;
    logic signed [31:0] out_iy_reg;
    logic signed [31:0] out_iz_reg;
    logic [1:0]         out_st_reg;
    logic signed [67:0] o_wx;
    logic signed [67:0] o_wy;
    logic signed [67:0] o_wz;
    logic signed [67:0] o_ix;
    logic signed [67:0] o_iy;
    logic signed [67:0] o_iz;
    logic               o_sat;

    always_comb
    begin
        o_wx  = 68'((b4_px_reg + 66'sd536870912) >>> 30);
        o_wy  = 68'((b4_py_reg + 66'sd536870912) >>> 30);
        o_wz  = 68'((b4_pz_reg + 66'sd536870912) >>> 30);
        o_ix  = o_wx - 68'(b4_side_reg.vx);
        o_iy  = o_wy - 68'(b4_side_reg.vy);
        o_iz  = o_wz - 68'(b4_side_reg.vz);
        o_sat = b4_side_reg.sat || ovf32(o_wx) || ovf32(o_wy) || ovf32(o_wz)
                || ovf32(o_ix) || ovf32(o_iy) || ovf32(o_iz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg       <= 1'b0;
            b2_v_reg       <= 1'b0;
            b3_v_reg       <= 1'b0;
            b4_v_reg       <= 1'b0;
            wake_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_v_reg       <= rot_v;
            b2_v_reg       <= b1_v_reg;
            b3_v_reg       <= b2_v_reg;
            b4_v_reg       <= b3_v_reg;
            wake_valid_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_c_reg    <= rot_side.flip ? -rot_c : rot_c;
            b1_s_reg    <= rot_side.flip ? -rot_s : rot_s;
            b1_side_reg <= rot_side;
            b2_cvx_reg  <= 66'(b1_c_reg) * 66'(b1_side_reg.vx);
            b2_svz_reg  <= 66'(b1_s_reg) * 66'(b1_side_reg.vz);
            b2_cvz_reg  <= 66'(b1_c_reg) * 66'(b1_side_reg.vz);
            b2_svx_reg  <= 66'(b1_s_reg) * 66'(b1_side_reg.vx);
            b2_side_reg <= b1_side_reg;
            b3_rx_reg   <= b3_rx_next;
            b3_rz_reg   <= b3_rz_next;
            b3_side_reg <= b2_side_reg;
            b4_px_reg   <= 66'(b3_rx_reg) * 66'(b4_scale);
            b4_py_reg   <= 66'(b3_side_reg.vy) * 66'(b4_scale);
            b4_pz_reg   <= 66'(b3_rz_reg) * 66'(b4_scale);
            b4_side_reg <= b3_side_reg;
            if (b4_side_reg.zero)
            begin
                out_dw_reg <= '0;
                out_wx_reg <= '0;
                out_wy_reg <= '0;
                out_wz_reg <= '0;
                out_ix_reg <= '0;
                out_iy_reg <= '0;
                out_iz_reg <= '0;
                out_st_reg <= ST_ZERO;
            end
            else
            begin
                out_dw_reg <= b4_side_reg.dw;
                out_wx_reg <= sat32(o_wx);
                out_wy_reg <= sat32(o_wy);
                out_wz_reg <= sat32(o_wz);
                out_ix_reg <= sat32(o_ix);
                out_iy_reg <= sat32(o_iy);
                out_iz_reg <= sat32(o_iz);
                out_st_reg <= o_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign wake.valid          = wake_valid_reg;
    assign wake.downwash_angle = out_dw_reg;
    assign wake.wake_x         = out_wx_reg;
    assign wake.wake_y         = out_wy_reg;
    assign wake.wake_z         = out_wz_reg;
    assign wake.incr_x         = out_ix_reg;
    assign wake.incr_y         = out_iy_reg;
    assign wake.incr_z         = out_iz_reg;
    assign wake.status         = out_st_reg;

    `ASSERT_CLK(a_zero_beat, clk, rst_n, (wake.valid && wake.status == ST_ZERO) |-> (wake.wake_x == 32'sd0 && wake.wake_y == 32'sd0 && wake.incr_z == 32'sd0 && wake.downwash_angle == 32'sd0))
    `ASSERT_CLK(a_status_code, clk, rst_n, wake.valid |-> (wake.status == ST_OK || wake.status == ST_ZERO || wake.status == ST_SAT))
    `ASSERT_CLK(a_sqrt_start, clk, rst_n, (cfg_wr && cfg_idx == REG_PRESSURE_RATIO) |=> sq_busy_reg)
    `ASSERT_NEVER(a_no_take_busy, clk, rst_n, sq_busy_reg && vel.ready)

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Downwash wake block testbench
// Drives velocity beats and register writes into wing_tail_downwash_wake,
// predicts every wake beat with a bit-exact fixed-point CORDIC model, and
// compares the beats field by field in arrival order, with and without random stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import wtdw_pkg::*;

    localparam int NSTG       = 24;
    localparam int LATENCY    = 2 * NSTG + 12;
    localparam int CYCLE_CAP  = 600000;
    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint TWO_PI_Q28  = 64'sd1686629713;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint ROT_MAX     = 64'sd4294967295;

    typedef struct packed {
        logic signed [31:0] downwash_angle;
        logic signed [31:0] wake_x;
        logic signed [31:0] wake_y;
        logic signed [31:0] wake_z;
        logic signed [31:0] incr_x;
        logic signed [31:0] incr_y;
        logic signed [31:0] incr_z;
        logic [1:0]         status;
    } wake_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wtdw_in_if  vel_if();
    wtdw_out_if wake_if();

    wing_tail_downwash_wake DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .vel     (vel_if.sink),
        .wake    (wake_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    longint     arc_tab [32];
    longint     rot_gain;
    longint     cfg_body_alpha;
    longint     cfg_downwash;
    longint     cfg_alpha_grad;
    longint     cfg_flap_ref;
    longint     cfg_flap_grad;
    longint     cfg_pressure;
    wake_beat_t wake_expected [$];
    int         mismatches;
    int         cycles;
    bit         gaps_on;

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint shr_round(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic bit [63:0] int_root(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void build_arc_table();
        bit [63:0] sum;
        bit [63:0] k2;
        int        k;
        arc_tab[0] = 64'sd210828714;
        for (int i = 1; i < 32; i++)
        begin
            sum = 0;
            for (k = 0; i * (2 * k + 1) <= 60; k++)
            begin
                if (k % 2 == 1)
                begin
                    sum = sum - (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
                end
                else
                begin
                    sum = sum + (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
                end
            end
            arc_tab[i] = longint'((sum + (64'd1 << 31)) >> 32);
        end
        k2 = 64'd1 << 62;
        for (int i = 0; i < NSTG; i++)
        begin
            k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
        end
        rot_gain = longint'((int_root(k2) + 1) >> 1);
    endfunction

    function automatic longint attack_angle(longint z, longint x);
        longint    ang;
        longint    t;
        bit [63:0] m;
        bit [63:0] az;
        ang = 0;
        if (x == 0 && z == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            ang = (z >= 0) ? PI_Q28 : -PI_Q28;
            x = -x;
            z = -z;
        end
        az = (z < 0) ? -z : z;
        m = (x > az) ? x : az;
        while (m < (64'd1 << 40))
        begin
            m = m << 1;
            x = x * 2;
            z = z * 2;
        end
        for (int i = 0; i < NSTG; i++)
        begin
            t = x;
            if (z >= 0)
            begin
                x = x + (z >>> i);
                z = z - (t >>> i);
                ang = ang + arc_tab[i];
            end
            else
            begin
                x = x - (z >>> i);
                z = z + (t >>> i);
                ang = ang - arc_tab[i];
            end
        end
        return ang;
    endfunction

    function automatic void turn_cos_sin(longint a, output longint c, output longint s);
        longint x;
        longint y;
        longint t;
        bit     flip;
        x = rot_gain;
        y = 0;
        flip = 0;
        while (a > PI_Q28)
        begin
            a = a - TWO_PI_Q28;
        end
        while (a < -PI_Q28)
        begin
            a = a + TWO_PI_Q28;
        end
        if (a > HALF_PI_Q28)
        begin
            a = a - PI_Q28;
            flip = 1;
        end
        else if (a < -HALF_PI_Q28)
        begin
            a = a + PI_Q28;
            flip = 1;
        end
        for (int i = 0; i < NSTG; i++)
        begin
            t = x;
            if (a >= 0)
            begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                a = a - arc_tab[i];
            end
            else
            begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                a = a + arc_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clip_rot(longint v);
        if (v > ROT_MAX)
        begin
            return ROT_MAX;
        end
        if (v < -ROT_MAX)
        begin
            return -ROT_MAX;
        end
        return v;
    endfunction

    function automatic wake_beat_t predict_wake(logic signed [31:0] ix, logic signed [31:0] iy,
                                                logic signed [31:0] iz, logic signed [31:0] fl);
        wake_beat_t r;
        longint     vx;
        longint     vy;
        longint     vz;
        longint     alpha;
        longint     dw;
        longint     c;
        longint     s;
        longint     scale;
        longint     rx;
        longint     rz;
        longint     w [3];
        longint     v [3];
        longint     o [6];
        bit [63:0]  xr;
        bit [63:0]  sq;
        bit         sat;
        vx = ix;
        vy = iy;
        vz = iz;
        sat = 0;
        if (vx == 0 && vy == 0 && vz == 0)
        begin
            r = '0;
            r.status = ST_ZERO;
            return r;
        end
        alpha = attack_angle(vz, vx);
        dw = cfg_downwash + shr_round(cfg_alpha_grad * (alpha - cfg_body_alpha), 28)
           + shr_round(cfg_flap_grad * (longint'(fl) - cfg_flap_ref), 28);
        dw = clip32(dw, sat);
        turn_cos_sin(dw, c, s);
        xr = cfg_pressure << 30;
        sq = int_root(xr);
        if (xr - sq * sq > sq)
        begin
            sq = sq + 1;
        end
        scale = longint'(sq);
        rx = clip_rot(shr_round(c * vx + s * vz, 30));
        rz = clip_rot(shr_round(c * vz - s * vx, 30));
        w[0] = shr_round(rx * scale, 30);
        w[1] = shr_round(vy * scale, 30);
        w[2] = shr_round(rz * scale, 30);
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (int j = 0; j < 3; j++)
        begin
            o[j] = clip32(w[j], sat);
            o[3 + j] = clip32(w[j] - v[j], sat);
        end
        r.downwash_angle = dw[31:0];
        r.wake_x = o[0][31:0];
        r.wake_y = o[1][31:0];
        r.wake_z = o[2][31:0];
        r.incr_x = o[3][31:0];
        r.incr_y = o[4][31:0];
        r.incr_z = o[5][31:0];
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            wake_if.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            wake_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            wake_if.ready <= 1'b1;
        end
        else
        begin
            wake_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        wake_beat_t got;
        wake_beat_t want;
        if (rst_n && wake_if.valid && wake_if.ready)
        begin
            got.downwash_angle = wake_if.downwash_angle;
            got.wake_x = wake_if.wake_x;
            got.wake_y = wake_if.wake_y;
            got.wake_z = wake_if.wake_z;
            got.incr_x = wake_if.incr_x;
            got.incr_y = wake_if.incr_y;
            got.incr_z = wake_if.incr_z;
            got.status = wake_if.status;
            if (wake_expected.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected wake beat %p", got);
                end
            end
            else
            begin
                want = wake_expected.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("wake mismatch: expected %p", want);
                        $display("               actual   %p", got);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_BODY_ALPHA: cfg_body_alpha = longint'(signed'(value));
            REG_REF_DOWNWASH:   cfg_downwash   = longint'(signed'(value));
            REG_ALPHA_GRADIENT: cfg_alpha_grad = longint'(signed'(value));
            REG_REF_FLAP:       cfg_flap_ref   = longint'(signed'(value));
            REG_FLAP_GRADIENT:  cfg_flap_grad  = longint'(signed'(value));
            REG_PRESSURE_RATIO: cfg_pressure   = longint'(value);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        vel_if.valid <= 1'b0;
        while (wake_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_config(logic [31:0] ba, logic [31:0] rd, logic [31:0] ag,
                               logic [31:0] rf, logic [31:0] fg, logic [31:0] pr);
        wait_idle();
        write_reg(REG_REF_BODY_ALPHA, ba);
        write_reg(REG_REF_DOWNWASH, rd);
        write_reg(REG_ALPHA_GRADIENT, ag);
        write_reg(REG_REF_FLAP, rf);
        write_reg(REG_FLAP_GRADIENT, fg);
        write_reg(REG_PRESSURE_RATIO, pr);
    endtask

    task automatic send_velocity(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [31:0] f);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            vel_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        vel_if.valid      <= 1'b1;
        vel_if.vel_x      <= x;
        vel_if.vel_y      <= y;
        vel_if.vel_z      <= z;
        vel_if.flap_angle <= f;
        do
        begin
            @(posedge clk);
        end
        while (!vel_if.ready);
        wake_expected.push_back(predict_wake(x, y, z, f));
    endtask

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 13107200)) - 6553600);
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return 32'($signed($urandom_range(0, 131072000)) - 65536000);
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom();
        end
        return 32'($signed($urandom_range(0, 600000000)) - 300000000);
    endfunction

    task automatic send_random(int n);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        for (int i = 0; i < n; i++)
        begin
            x = rand_speed();
            y = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_speed();
            z = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_speed();
            if ($urandom_range(0, 40) == 0)
            begin
                x = 0;
                y = 0;
                z = 0;
            end
            send_velocity(x, y, z, rand_angle());
        end
    endtask

    task automatic test_directed();
        send_velocity(32'd0, 32'd0, 32'd0, 32'h1234_5678);
        send_velocity(32'd0, 32'd655360, 32'd0, 32'd0);
        send_velocity(32'd3276800, 32'd0, 32'd327680, 32'd0);
        send_velocity(-32'sd3276800, 32'd0, 32'd327680, 32'd0);
        send_velocity(-32'sd3276800, 32'd0, -32'sd327680, 32'd0);
        send_velocity(-32'sd3276800, 32'd100, 32'd0, 32'd0);
        send_velocity(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_velocity(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_velocity(32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
        send_velocity(32'd0, 32'd0, -32'sd1, 32'd0);
        send_velocity(32'd1, 32'd0, 32'd0, 32'd0);
        load_config(32'h1000_0000, 32'h0200_0000, 32'h0800_0000, 32'hf000_0000,
                    32'h0400_0000, 32'h6000_0000);
        send_velocity(32'd3276800, 32'd65536, 32'd655360, 32'h0800_0000);
        send_velocity(-32'sd3276800, -32'sd65536, 32'd655360, 32'hf800_0000);
        send_velocity(32'h7fff_ffff, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
        load_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'hffff_ffff);
        send_velocity(32'd3276800, 32'd65536, 32'd655360, 32'h8000_0000);
        send_velocity(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        load_config(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'd1);
        send_velocity(32'd3276800, 32'd65536, -32'sd655360, 32'h7fff_ffff);
        send_velocity(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    endtask

    task automatic test_config_sweep();
        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, SCALE_ONE);
        send_random(150);
        for (int p = 0; p < 4; p++)
        begin
            load_config(rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                        rand_angle(), $urandom_range(1, 32'h8000_0000));
            send_random(100);
        end
        load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom() | 32'd1);
        send_random(100);
    endtask

    task automatic test_drain_pause();
        send_random(30);
        wait_idle();
        send_random(30);
    endtask

    task automatic test_no_gaps();
        gaps_on = 0;
        load_config(32'h0100_0000, 32'hff00_0000, 32'h1000_0000, 32'd0,
                    32'h0800_0000, 32'h3000_0000);
        send_random(100);
    endtask

    initial
    begin
        clk = 1'b0;
        build_arc_table();
        cfg_body_alpha = 0;
        cfg_downwash   = 0;
        cfg_alpha_grad = 0;
        cfg_flap_ref   = 0;
        cfg_flap_grad  = 0;
        cfg_pressure   = 64'd1073741824;
        mismatches = 0;
        cycles = 0;
        gaps_on = 1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vel_if.valid = 1'b0;
        vel_if.vel_x = '0;
        vel_if.vel_y = '0;
        vel_if.vel_z = '0;
        vel_if.flap_angle = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_drain_pause();
        test_no_gaps();
        wait_idle();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && wake_expected.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
